// ===== hdl/printf_format_stream_formatter_assert.svh =====
// Assertion macros for the formatter RTL (included by pfsf_ctrl)
`ifndef PRINTF_FORMAT_STREAM_FORMATTER_ASSERT_SVH
`define PRINTF_FORMAT_STREAM_FORMATTER_ASSERT_SVH

`ifndef SYNTH
`define PFSF_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");
`define PFSF_ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("forbidden condition seen");
`else
`define PFSF_ASSERT(lbl, clk, rstn, prop)
`define PFSF_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

// ===== hdl/pfsf_pkg.sv =====
package pfsf_pkg;

    localparam int VAL_W  = 64;
    localparam int DIGITS = 20;
    localparam int DIG_W  = DIGITS * 4;
    localparam int NDIG_W = $clog2(DIGITS + 1);
    localparam int HEX_DIGITS = VAL_W / 4;
    localparam int CNT_W  = $clog2(VAL_W);
    localparam int NULL_LEN = 6;

    // item kinds
    localparam logic [1:0] CMD_FMT  = 2'd0;
    localparam logic [1:0] CMD_ARG  = 2'd1;
    localparam logic [1:0] CMD_STR  = 2'd2;
    localparam logic [1:0] CMD_NULL = 2'd3;

    // expecting codes
    localparam logic [1:0] EXP_FMT = 2'd0;
    localparam logic [1:0] EXP_ARG = 2'd1;
    localparam logic [1:0] EXP_STR = 2'd2;

    // config register indexes
    localparam logic CFG_CAPACITY = 1'b0;
    localparam logic CFG_LONG64   = 1'b1;

    localparam logic [15:0] CAP_RESET = 16'd256;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_S     = 8'h73;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  char_code;
        logic [63:0] arg_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_char;
        logic [15:0] out_index;
        logic        stored;
        logic        last;
        logic        done_res;
        logic [15:0] final_length;
        logic [1:0]  expecting;
        logic        bad_item;
    } t_out_item;

    typedef enum logic [2:0] {
        M_PLAIN, M_PCT, M_LONGS, M_ARG, M_STR_FIRST, M_STR_MORE
    } t_mode;

    typedef enum logic [2:0] {
        K_NONE, K_SIGNED, K_UDEC, K_HEX, K_PTR, K_STR
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECODE, ST_ECHO, ST_NULLS, ST_DABBLE,
        ST_SIGN, ST_PFX0, ST_PFXX, ST_SKIP, ST_DIGITS
    } t_state;

    typedef enum logic [2:0] {
        DEC_SILENT, DEC_BAD, DEC_TERM, DEC_EMIT, DEC_PCTE, DEC_ECHO, DEC_ARG, DEC_NULL
    } t_dec;

    typedef enum logic [1:0] {
        ES_ITEM, ES_CONST, ES_DIGIT
    } t_emit_sel;

    typedef enum logic [1:0] {
        EK_NORM, EK_TERM, EK_BAD
    } t_emit_kind;

    typedef struct packed {
        logic       accept;
        logic       load;
        logic       dab_step;
        logic       shift;
        logic       emit;
        t_emit_sel  sel;
        t_emit_kind kind;
        logic [7:0] ch;
        logic       last;
        logic [1:0] expect_code;
        t_kind      conv_kind;
        logic [1:0] long_count;
    } t_ctrl_cmd;

    typedef struct packed {
        logic [1:0] item_cmd;
        logic [7:0] item_char;
        logic       out_free;
        logic       neg;
        logic       top_zero;
        logic       ndig_one;
        logic       dab_last;
    } t_dp_status;

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h57 + {4'h0, n});
    endfunction

    function automatic logic [7:0] null_char(input logic [2:0] k);
        logic [7:0] c;
        case (k)
            3'd0:    c = 8'h28;  // (
            3'd1:    c = 8'h6E;  // n
            3'd2:    c = 8'h75;  // u
            3'd3:    c = 8'h6C;  // l
            3'd4:    c = 8'h6C;  // l
            3'd5:    c = 8'h29;  // )
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] expect_of(input t_mode m);
        logic [1:0] e;
        case (m) inside
            M_ARG:                  e = EXP_ARG;
            M_STR_FIRST, M_STR_MORE: e = EXP_STR;
            default:                e = EXP_FMT;
        endcase
        return e;
    endfunction

endpackage

// ===== hdl/printf_format_stream_formatter.sv =====
// printf-style stream formatter.
// Input channel (i_in_valid / o_in_stall) carries format characters and the
// arguments of conversions; output channel (o_out_valid / i_out_stall) carries
// one character per transfer with its buffer index, stored flag, last-of-item
// mark, and on the terminator the returned length. Configuration writes
// (capacity, long_is_64) use i_cfg_valid / o_cfg_ready, always ready.
// One item is processed at a time: accepted in ST_IDLE, decoded in ST_DECODE,
// then written to the output register; the next item is taken back in ST_IDLE.
// Decimal conversions run a 64-step shift-and-add-3 binary-to-BCD unit, then
// skip leading zero digits (keeping one) and emit the rest, after a minus sign
// when negative. Hex arguments, and pointers after "0x", do the same without
// the BCD step; a null string gives "(null)", an unknown letter echoes '%' and
// the letter. Each emitted character needs a free output register: while it
// is full and the receiver stalls, an emitting state holds; o_in_stall stays high.
// Synchronous reset returns capacity to 256, long_is_64 to 1, the parser to
// plain text and the character count to zero.
module printf_format_stream_formatter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pfsf_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pfsf_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [15:0]         i_cfg_data
);

    pfsf_pkg::t_ctrl_cmd  w_cmd;
    pfsf_pkg::t_dp_status w_sts;

    assign o_cfg_ready = 1'b1;

    pfsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pfsf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== hdl/pfsf_ctrl.sv =====
`include "printf_format_stream_formatter_assert.svh"

module pfsf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  pfsf_pkg::t_dp_status i_sts,
    output pfsf_pkg::t_ctrl_cmd  o_cmd
);

    pfsf_pkg::t_state r_state, n_state;
    pfsf_pkg::t_mode  r_mode, d_mode;
    pfsf_pkg::t_kind  r_kind, d_kind, l_kind;
    logic [1:0]       r_long, d_long;
    logic [2:0]       r_nk;
    pfsf_pkg::t_dec   d_act;
    pfsf_pkg::t_mode  l_mode;
    logic             l_known;
    logic             d_ok;
    logic             w_accept;
    logic             w_free;

    assign w_accept   = i_in_valid && (r_state == pfsf_pkg::ST_IDLE);
    assign o_in_stall = (r_state != pfsf_pkg::ST_IDLE);
    assign w_free     = i_sts.out_free;

    // conversion letter lookup
    always_comb begin
        l_known = 1'b1;
        l_kind  = pfsf_pkg::K_NONE;
        l_mode  = pfsf_pkg::M_ARG;
        case (i_sts.item_char) inside
            pfsf_pkg::CH_D, pfsf_pkg::CH_I: l_kind = pfsf_pkg::K_SIGNED;
            pfsf_pkg::CH_U: l_kind = pfsf_pkg::K_UDEC;
            pfsf_pkg::CH_X: l_kind = pfsf_pkg::K_HEX;
            pfsf_pkg::CH_P: l_kind = pfsf_pkg::K_PTR;
            pfsf_pkg::CH_S: begin
                l_kind = pfsf_pkg::K_STR;
                l_mode = pfsf_pkg::M_STR_FIRST;
            end
            default: begin
                l_known = 1'b0;
                l_mode  = pfsf_pkg::M_PLAIN;
            end
        endcase
    end

    // item decode against the parse mode
    always_comb begin
        d_act  = pfsf_pkg::DEC_SILENT;
        d_mode = r_mode;
        d_long = r_long;
        d_kind = r_kind;
        unique case (r_mode)
            pfsf_pkg::M_ARG:       d_ok = (i_sts.item_cmd == pfsf_pkg::CMD_ARG);
            pfsf_pkg::M_STR_FIRST: d_ok = (i_sts.item_cmd == pfsf_pkg::CMD_STR) ||
                                          (i_sts.item_cmd == pfsf_pkg::CMD_NULL);
            pfsf_pkg::M_STR_MORE:  d_ok = (i_sts.item_cmd == pfsf_pkg::CMD_STR);
            default:               d_ok = (i_sts.item_cmd == pfsf_pkg::CMD_FMT);
        endcase
        if (!d_ok) begin
            d_act = pfsf_pkg::DEC_BAD;
        end else begin
            unique case (r_mode)
                pfsf_pkg::M_PCT, pfsf_pkg::M_LONGS: begin
                    if (i_sts.item_char == pfsf_pkg::CH_NUL) begin
                        d_act = pfsf_pkg::DEC_TERM;
                    end else if (r_mode == pfsf_pkg::M_PCT &&
                                 i_sts.item_char == pfsf_pkg::CH_PCT) begin
                        d_act  = pfsf_pkg::DEC_PCTE;
                        d_mode = pfsf_pkg::M_PLAIN;
                    end else if (i_sts.item_char == pfsf_pkg::CH_L) begin
                        d_mode = pfsf_pkg::M_LONGS;
                        if (r_mode == pfsf_pkg::M_PCT) begin
                            d_long = 2'd1;
                        end else if (r_long != 2'd2) begin
                            d_long = r_long + 2'd1;
                        end
                    end else if (l_known) begin
                        d_kind = l_kind;
                        d_mode = l_mode;
                    end else begin
                        d_act  = pfsf_pkg::DEC_ECHO;
                        d_mode = pfsf_pkg::M_PLAIN;
                    end
                end
                pfsf_pkg::M_ARG: begin
                    d_act  = pfsf_pkg::DEC_ARG;
                    d_mode = pfsf_pkg::M_PLAIN;
                    d_long = 2'd0;
                end
                pfsf_pkg::M_STR_FIRST, pfsf_pkg::M_STR_MORE: begin
                    if (i_sts.item_cmd == pfsf_pkg::CMD_NULL) begin
                        d_act  = pfsf_pkg::DEC_NULL;
                        d_mode = pfsf_pkg::M_PLAIN;
                        d_long = 2'd0;
                    end else if (i_sts.item_char == pfsf_pkg::CH_NUL) begin
                        d_mode = pfsf_pkg::M_PLAIN;
                        d_long = 2'd0;
                    end else begin
                        d_act  = pfsf_pkg::DEC_EMIT;
                        d_mode = pfsf_pkg::M_STR_MORE;
                    end
                end
                default: begin
                    if (i_sts.item_char == pfsf_pkg::CH_NUL) begin
                        d_act = pfsf_pkg::DEC_TERM;
                    end else if (i_sts.item_char == pfsf_pkg::CH_PCT) begin
                        d_mode = pfsf_pkg::M_PCT;
                        d_long = 2'd0;
                    end else begin
                        d_act = pfsf_pkg::DEC_EMIT;
                    end
                end
            endcase
            if (d_act == pfsf_pkg::DEC_TERM) begin
                d_mode = pfsf_pkg::M_PLAIN;
                d_long = 2'd0;
                d_kind = pfsf_pkg::K_NONE;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pfsf_pkg::ST_IDLE: begin
                if (w_accept) n_state = pfsf_pkg::ST_DECODE;
            end
            pfsf_pkg::ST_DECODE: begin
                if (w_free) begin
                    case (d_act)
                        pfsf_pkg::DEC_ARG: begin
                            if (r_kind == pfsf_pkg::K_SIGNED || r_kind == pfsf_pkg::K_UDEC)
                                n_state = pfsf_pkg::ST_DABBLE;
                            else if (r_kind == pfsf_pkg::K_PTR)
                                n_state = pfsf_pkg::ST_PFX0;
                            else
                                n_state = pfsf_pkg::ST_SKIP;
                        end
                        pfsf_pkg::DEC_ECHO: n_state = pfsf_pkg::ST_ECHO;
                        pfsf_pkg::DEC_NULL: n_state = pfsf_pkg::ST_NULLS;
                        default:            n_state = pfsf_pkg::ST_IDLE;
                    endcase
                end
            end
            pfsf_pkg::ST_ECHO: begin
                if (w_free) n_state = pfsf_pkg::ST_IDLE;
            end
            pfsf_pkg::ST_NULLS: begin
                if (w_free && r_nk == 3'(pfsf_pkg::NULL_LEN - 1)) n_state = pfsf_pkg::ST_IDLE;
            end
            pfsf_pkg::ST_DABBLE: begin
                if (i_sts.dab_last)
                    n_state = i_sts.neg ? pfsf_pkg::ST_SIGN : pfsf_pkg::ST_SKIP;
            end
            pfsf_pkg::ST_SIGN: begin
                if (w_free) n_state = pfsf_pkg::ST_SKIP;
            end
            pfsf_pkg::ST_PFX0: begin
                if (w_free) n_state = pfsf_pkg::ST_PFXX;
            end
            pfsf_pkg::ST_PFXX: begin
                if (w_free) n_state = pfsf_pkg::ST_SKIP;
            end
            pfsf_pkg::ST_SKIP: begin
                if (!(i_sts.top_zero && !i_sts.ndig_one)) n_state = pfsf_pkg::ST_DIGITS;
            end
            pfsf_pkg::ST_DIGITS: begin
                if (w_free && i_sts.ndig_one) n_state = pfsf_pkg::ST_IDLE;
            end
            default: n_state = pfsf_pkg::ST_IDLE;
        endcase
    end

    // commands to the datapath
    always_comb begin
        o_cmd             = '0;
        o_cmd.sel         = pfsf_pkg::ES_CONST;
        o_cmd.kind        = pfsf_pkg::EK_NORM;
        o_cmd.conv_kind   = r_kind;
        o_cmd.long_count  = r_long;
        o_cmd.expect_code = pfsf_pkg::expect_of((r_state == pfsf_pkg::ST_DECODE) ? d_mode : r_mode);
        unique case (r_state)
            pfsf_pkg::ST_IDLE: o_cmd.accept = w_accept;
            pfsf_pkg::ST_DECODE: begin
                if (w_free) begin
                    case (d_act)
                        pfsf_pkg::DEC_BAD: begin
                            o_cmd.emit = 1'b1;
                            o_cmd.kind = pfsf_pkg::EK_BAD;
                            o_cmd.last = 1'b1;
                        end
                        pfsf_pkg::DEC_TERM: begin
                            o_cmd.emit = 1'b1;
                            o_cmd.kind = pfsf_pkg::EK_TERM;
                            o_cmd.last = 1'b1;
                        end
                        pfsf_pkg::DEC_EMIT: begin
                            o_cmd.emit = 1'b1;
                            o_cmd.sel  = pfsf_pkg::ES_ITEM;
                            o_cmd.last = 1'b1;
                        end
                        pfsf_pkg::DEC_PCTE: begin
                            o_cmd.emit = 1'b1;
                            o_cmd.ch   = pfsf_pkg::CH_PCT;
                            o_cmd.last = 1'b1;
                        end
                        pfsf_pkg::DEC_ECHO: begin
                            o_cmd.emit = 1'b1;
                            o_cmd.ch   = pfsf_pkg::CH_PCT;
                        end
                        pfsf_pkg::DEC_ARG: o_cmd.load = 1'b1;
                        default: ;
                    endcase
                end
            end
            pfsf_pkg::ST_ECHO: begin
                o_cmd.emit = w_free;
                o_cmd.sel  = pfsf_pkg::ES_ITEM;
                o_cmd.last = 1'b1;
            end
            pfsf_pkg::ST_NULLS: begin
                o_cmd.emit = w_free;
                o_cmd.ch   = pfsf_pkg::null_char(r_nk);
                o_cmd.last = (r_nk == 3'(pfsf_pkg::NULL_LEN - 1));
            end
            pfsf_pkg::ST_DABBLE: o_cmd.dab_step = 1'b1;
            pfsf_pkg::ST_SIGN: begin
                o_cmd.emit = w_free;
                o_cmd.ch   = pfsf_pkg::CH_MINUS;
            end
            pfsf_pkg::ST_PFX0: begin
                o_cmd.emit = w_free;
                o_cmd.ch   = pfsf_pkg::CH_ZERO;
            end
            pfsf_pkg::ST_PFXX: begin
                o_cmd.emit = w_free;
                o_cmd.ch   = pfsf_pkg::CH_X;
            end
            pfsf_pkg::ST_SKIP: o_cmd.shift = i_sts.top_zero && !i_sts.ndig_one;
            pfsf_pkg::ST_DIGITS: begin
                o_cmd.emit  = w_free;
                o_cmd.sel   = pfsf_pkg::ES_DIGIT;
                o_cmd.last  = i_sts.ndig_one;
                o_cmd.shift = w_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfsf_pkg::ST_IDLE;
            r_mode  <= pfsf_pkg::M_PLAIN;
            r_kind  <= pfsf_pkg::K_NONE;
            r_long  <= 2'd0;
            r_nk    <= 3'd0;
        end else begin
            r_state <= n_state;
            if (r_state == pfsf_pkg::ST_DECODE && w_free) begin
                r_mode <= d_mode;
                r_kind <= d_kind;
                r_long <= d_long;
                r_nk   <= 3'd0;
            end else if (r_state == pfsf_pkg::ST_NULLS && w_free) begin
                r_nk <= r_nk + 3'd1;
            end
        end
    end

    `PFSF_ASSERT(a_accept_to_decode, i_clk, i_rst_n, o_cmd.accept |=> r_state == pfsf_pkg::ST_DECODE)
    `PFSF_ASSERT_NEVER(a_emit_into_full, i_clk, i_rst_n, o_cmd.emit && !i_sts.out_free)
    `PFSF_ASSERT(a_digit_last, i_clk, i_rst_n, (o_cmd.emit && r_state == pfsf_pkg::ST_DIGITS) |-> (o_cmd.last == i_sts.ndig_one))

endmodule

// ===== hdl/pfsf_dp.sv =====
module pfsf_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pfsf_pkg::t_in_item   i_in_item,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_out_stall,
    input  pfsf_pkg::t_ctrl_cmd  i_cmd,
    output pfsf_pkg::t_dp_status o_sts,
    output logic                 o_out_valid,
    output pfsf_pkg::t_out_item  o_out_item
);

    logic [15:0]                   r_cap;
    logic                          r_l64;
    pfsf_pkg::t_in_item            r_item;
    logic [pfsf_pkg::VAL_W-1:0]    r_val;
    logic [pfsf_pkg::DIG_W-1:0]    r_dig;
    logic [pfsf_pkg::NDIG_W-1:0]   r_ndig;
    logic [pfsf_pkg::CNT_W-1:0]    r_cnt;
    logic                          r_neg;
    logic [15:0]                   r_wc;
    logic                          r_out_valid;
    pfsf_pkg::t_out_item           r_out;

    logic                          w_wide;
    logic                          w_signed;
    logic                          w_hex;
    logic [pfsf_pkg::VAL_W-1:0]    w_ext;
    logic                          w_neg;
    logic [pfsf_pkg::VAL_W-1:0]    w_mag;
    logic [pfsf_pkg::DIG_W-1:0]    w_adj;
    logic [15:0]                   w_cap_m1;
    logic [15:0]                   w_len;
    logic                          w_stored;
    logic [7:0]                    w_char;
    logic [3:0]                    w_top;

    assign w_top = r_dig[pfsf_pkg::DIG_W-1 -: 4];

    // argument width, sign extension and magnitude
    always_comb begin
        if (i_cmd.conv_kind == pfsf_pkg::K_PTR)
            w_wide = r_l64;
        else if (i_cmd.long_count == 2'd0)
            w_wide = 1'b0;
        else if (i_cmd.long_count == 2'd1)
            w_wide = r_l64;
        else
            w_wide = 1'b1;
        w_signed = (i_cmd.conv_kind == pfsf_pkg::K_SIGNED);
        w_hex    = (i_cmd.conv_kind == pfsf_pkg::K_HEX) || (i_cmd.conv_kind == pfsf_pkg::K_PTR);
        w_ext    = w_wide ? r_item.arg_value
                          : {{32{w_signed & r_item.arg_value[31]}}, r_item.arg_value[31:0]};
        w_neg    = w_signed & w_ext[pfsf_pkg::VAL_W-1];
        w_mag    = w_neg ? (~w_ext + 64'd1) : w_ext;
    end

    // BCD add-3 on every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < pfsf_pkg::DIGITS; i++) begin
            w_adj[i*4 +: 4] = (r_dig[i*4 +: 4] >= 4'd5) ? (r_dig[i*4 +: 4] + 4'd3)
                                                       : r_dig[i*4 +: 4];
        end
    end

    always_comb begin
        w_cap_m1 = r_cap - 16'd1;
        if (r_cap == 16'd0)
            w_len = 16'd0;
        else if (r_wc > w_cap_m1)
            w_len = w_cap_m1;
        else
            w_len = r_wc;
        w_stored = ({1'b0, r_wc} + 17'd1) < {1'b0, r_cap};
        case (i_cmd.sel)
            pfsf_pkg::ES_ITEM:  w_char = r_item.char_code;
            pfsf_pkg::ES_DIGIT: w_char = pfsf_pkg::hex_char(w_top);
            default:            w_char = i_cmd.ch;
        endcase
    end

    always_comb begin
        o_sts.item_cmd  = r_item.command;
        o_sts.item_char = r_item.char_code;
        o_sts.out_free  = !r_out_valid || !i_out_stall;
        o_sts.neg       = r_neg;
        o_sts.top_zero  = (w_top == 4'd0);
        o_sts.ndig_one  = (r_ndig == pfsf_pkg::NDIG_W'(1));
        o_sts.dab_last  = (r_cnt == pfsf_pkg::CNT_W'(pfsf_pkg::VAL_W - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= pfsf_pkg::CAP_RESET;
            r_l64       <= 1'b1;
            r_wc        <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == pfsf_pkg::CFG_CAPACITY)
                    r_cap <= i_cfg_data;
                else
                    r_l64 <= i_cfg_data[0];
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                case (i_cmd.kind)
                    pfsf_pkg::EK_TERM: r_wc <= 16'd0;
                    pfsf_pkg::EK_NORM: if (r_wc != 16'hFFFF) r_wc <= r_wc + 16'd1;
                    default: ;
                endcase
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_item <= i_in_item;
        if (i_cmd.load) begin
            r_neg <= w_neg;
            r_cnt <= '0;
            if (w_hex) begin
                r_dig  <= {w_mag, {(pfsf_pkg::DIG_W - pfsf_pkg::VAL_W){1'b0}}};
                r_ndig <= pfsf_pkg::NDIG_W'(pfsf_pkg::HEX_DIGITS);
            end else begin
                r_val  <= w_mag;
                r_dig  <= '0;
                r_ndig <= pfsf_pkg::NDIG_W'(pfsf_pkg::DIGITS);
            end
        end else if (i_cmd.dab_step) begin
            r_dig <= {w_adj[pfsf_pkg::DIG_W-2:0], r_val[pfsf_pkg::VAL_W-1]};
            r_val <= {r_val[pfsf_pkg::VAL_W-2:0], 1'b0};
            r_cnt <= r_cnt + pfsf_pkg::CNT_W'(1);
        end else if (i_cmd.shift) begin
            r_dig  <= {r_dig[pfsf_pkg::DIG_W-5:0], 4'h0};
            r_ndig <= r_ndig - pfsf_pkg::NDIG_W'(1);
        end
        if (i_cmd.emit) begin
            r_out.out_char     <= w_char;
            r_out.out_index    <= r_wc;
            r_out.stored       <= w_stored;
            r_out.last         <= i_cmd.last;
            r_out.done_res     <= 1'b0;
            r_out.final_length <= 16'd0;
            r_out.expecting    <= i_cmd.expect_code;
            r_out.bad_item     <= 1'b0;
            case (i_cmd.kind)
                pfsf_pkg::EK_TERM: begin
                    r_out.out_char     <= pfsf_pkg::CH_NUL;
                    r_out.out_index    <= w_len;
                    r_out.stored       <= (r_cap != 16'd0);
                    r_out.done_res     <= 1'b1;
                    r_out.final_length <= w_len;
                end
                pfsf_pkg::EK_BAD: begin
                    r_out.out_char <= pfsf_pkg::CH_NUL;
                    r_out.stored   <= 1'b0;
                    r_out.bad_item <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
